FILE: rtl/core/irtx_pkg.sv
// Shared types and constants for the IR UART packet transmitter.
// No dependencies; imported by every module in rtl/core.
package irtx_pkg;

  localparam int unsigned BUF_DEPTH_DEF = 32;
  localparam int unsigned PERIOD_W      = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd13333;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BITCNT_W      = 4;

  // Item kinds on the input channel; the fourth code is unused.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  // Framing phase of the byte being sent.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  // One result word.
  typedef struct packed {
    logic led_on;
    logic busy;
    logic done;
  } res_t;

endpackage

FILE: rtl/core/ir_uart_packet_transmitter.sv
// IR UART packet transmitter: 8N1 framing of a buffered packet onto an LED.
// Top level; depends on irtx_pkg, irtx_buffer, irtx_framer, irtx_out_buf.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per item: mode_i
//   selects a buffer write (address_i, data_i), a start request, or one timer
//   tick. Every accepted word yields exactly one result word on the output
//   channel (out_valid_o/out_ready_i): LED level, busy flag, and a done pulse
//   on the tick that ends the packet.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i) sets the bit period
//   in ticks; always ready. The user must write it only while the block is
//   idle; the block does not enforce this. Throughput: one word per cycle
//   while in_ready_o is high; all framing work is combinational between the
//   state registers and the result register. The buffer read is registered
//   and tracks the next byte index, so the byte is ready when the start bit
//   is framed. Stall: results sit in an output register plus a skid entry;
//   in_ready_o drops only once both hold words.
//   Reset: LED off, idle, tick counter zero, bit period 13333. The packet
//   buffer is not cleared; bytes must be written before they are sent.
module ir_uart_packet_transmitter import irtx_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [BYTE_W-1:0]   data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                led_on_o,
  output logic                busy_res_o,
  output logic                done_res_o
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);

  logic              item;
  mode_e             mode;
  logic [IDX_W-1:0]  raddr;
  logic [BYTE_W-1:0] rdata;
  res_t              res, out_res;

  assign cfg_ready_o = 1'b1;
  assign item        = in_valid_i && in_ready_o;
  assign mode        = mode_e'(mode_i);

  irtx_buffer #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .IDX_W        (IDX_W)
  ) u_buffer (
    .clk_i   (clk_i),
    .we_i    (item && (mode == MODE_WRITE)),
    .waddr_i (address_i),
    .wdata_i (data_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  irtx_framer #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .IDX_W        (IDX_W)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .mode_i     (mode),
    .rdata_i    (rdata),
    .raddr_o    (raddr),
    .res_o      (res)
  );

  irtx_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item),
    .push_data_i (res),
    .room_o      (in_ready_o),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_res)
  );

  assign led_on_o   = out_res.led_on;
  assign busy_res_o = out_res.busy;
  assign done_res_o = out_res.done;

endmodule

FILE: rtl/core/irtx_buffer.sv
// Packet buffer: BUFFER_DEPTH x 8 memory, one write port, one registered read port.
// Depends on irtx_pkg.
module irtx_buffer import irtx_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUF_DEPTH_DEF,
  parameter int unsigned IDX_W        = $clog2(BUFFER_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  localparam int unsigned MW = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [IDX_W-1:0]  waddr;

  // Address modulo depth by repeated subtract (at most eight steps for depth >= 4).
  function automatic logic [IDX_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [MW-1:0] r;
    r = MW'(a);
    for (int k = 0; k < 8; k++) begin
      if (r >= MW'(BUFFER_DEPTH)) begin
        r = r - MW'(BUFFER_DEPTH);
      end
    end
    return r[IDX_W-1:0];
  endfunction

  assign waddr = wrap_addr(waddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr] <= wdata_i;
    end
  end

  // Read follows the next index; a same-cycle write to it is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/irtx_framer.sv
// Bit timer and 8N1 framing state for the packet transmitter.
// Depends on irtx_pkg; byte data comes from irtx_buffer.
module irtx_framer import irtx_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUF_DEPTH_DEF,
  parameter int unsigned IDX_W        = $clog2(BUFFER_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  input  logic                item_i,
  input  mode_e               mode_i,
  input  logic [BYTE_W-1:0]   rdata_i,
  output logic [IDX_W-1:0]    raddr_o,
  output res_t                res_o
);

  phase_e                phase_q, phase_d;
  logic [BITCNT_W-1:0]   bitcnt_q, bitcnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [BYTE_W-1:0]     byte_q, byte_d;
  logic                  last_q, last_d;
  logic [PERIOD_W-1:0]   tick_q, tick_d;
  logic                  led_q, led_d;
  logic                  active_q, active_d;
  logic [PERIOD_W-1:0]   period_q;
  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W:0]     tick_inc;
  logic                  is_tick, is_start, wrap, step, done;
  logic [IDX_W-1:0]      idx_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  assign period   = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign is_tick  = item_i && (mode_i == MODE_TICK);
  assign is_start = item_i && (mode_i == MODE_START) && !active_q;
  assign tick_inc = {1'b0, tick_q} + 1'b1;
  assign wrap     = tick_inc >= {1'b0, period};
  assign step     = is_tick && wrap && active_q;
  assign idx_next = (idx_q == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : idx_q + 1'b1;

  // Free-running tick counter.
  always_comb begin
    tick_d = tick_q;
    if (is_tick) begin
      tick_d = wrap ? '0 : tick_inc[PERIOD_W-1:0];
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_start) begin
      phase_d = PH_IDLE;
    end else if (step) begin
      unique case (phase_q)
        PH_IDLE:  phase_d = PH_START;
        PH_START: phase_d = PH_DATA;
        PH_DATA:  phase_d = (bitcnt_q >= BITCNT_W'(BYTE_W)) ? PH_STOP : PH_DATA;
        PH_STOP:  phase_d = last_q ? PH_IDLE : PH_START;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // Framing datapath.
  always_comb begin
    bitcnt_d = bitcnt_q;
    idx_d    = idx_q;
    byte_d   = byte_q;
    last_d   = last_q;
    led_d    = led_q;
    active_d = active_q;
    done     = 1'b0;
    if (is_start) begin
      active_d = 1'b1;
    end else if (step) begin
      unique case (phase_q)
        PH_IDLE: begin
          last_d = 1'b0;
          idx_d  = '0;
        end
        PH_START: begin
          led_d    = 1'b1;
          bitcnt_d = '0;
          byte_d   = rdata_i;
        end
        PH_DATA: begin
          if (bitcnt_q >= BITCNT_W'(BYTE_W)) begin
            led_d = 1'b0;
          end else begin
            led_d    = ~byte_q[bitcnt_q[2:0]];
            bitcnt_d = bitcnt_q + 1'b1;
          end
        end
        PH_STOP: begin
          if (last_q) begin
            active_d = 1'b0;
            done     = 1'b1;
          end else begin
            if (byte_q == '0) begin
              last_d = 1'b1;
            end
            idx_d = idx_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bitcnt_q <= '0;
      idx_q    <= '0;
      byte_q   <= '0;
      last_q   <= 1'b0;
      tick_q   <= '0;
      led_q    <= 1'b0;
      active_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      idx_q    <= idx_d;
      byte_q   <= byte_d;
      last_q   <= last_d;
      tick_q   <= tick_d;
      led_q    <= led_d;
      active_q <= active_d;
    end
  end

  assign raddr_o      = idx_d;
  assign res_o.led_on = led_d;
  assign res_o.busy   = active_d;
  assign res_o.done   = done;

endmodule

FILE: rtl/core/irtx_out_buf.sv
// Two-entry result buffer (output register plus skid) for the result channel.
// Depends on irtx_pkg for the result type.
module irtx_out_buf import irtx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic room_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic main_v_q, main_v_d, skid_v_q, skid_v_d;
  res_t main_q, main_d, skid_q, skid_d;

  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!main_v_q || ready_i) begin
      if (skid_v_q) begin
        main_v_d = 1'b1;
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push_i;
        main_d   = push_data_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign room_o  = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

endmodule

FILE: test/irtx_tb_pkg.sv
// Scoreboard for the IR UART packet transmitter bench: mirrors the bit framing
// and queues the expected result words. Depends on irtx_pkg.
`timescale 1ns / 1ps
package irtx_tb_pkg;
  import irtx_pkg::*;

  class led_frame_tracker;
    logic [PERIOD_W-1:0] period;
    phase_e              phase;
    logic [BITCNT_W-1:0] bit_idx;
    logic [ADDR_W-1:0]   byte_idx;
    logic [BYTE_W-1:0]   cur_byte;
    logic                nul_sent;
    logic [PERIOD_W-1:0] ticks;
    logic                led;
    logic                active;
    logic [BYTE_W-1:0]   buffer [BUF_DEPTH_DEF];
    res_t                expected_q [$];
    int unsigned         fails;

    function new();
      period   = PERIOD_RESET;
      phase    = PH_IDLE;
      bit_idx  = '0;
      byte_idx = '0;
      cur_byte = '0;
      nul_sent = 1'b0;
      ticks    = '0;
      led      = 1'b0;
      active   = 1'b0;
      fails    = 0;
      foreach (buffer[i]) buffer[i] = '0;
    endfunction

    function void set_period(logic [PERIOD_W-1:0] p);
      period = p;
    endfunction

    // One bit-period step; returns 1 on the step that closes the packet.
    function bit frame_step();
      bit fin;
      fin = 1'b0;
      case (phase)
        PH_IDLE: begin
          nul_sent = 1'b0;
          byte_idx = '0;
          phase    = PH_START;
        end
        PH_START: begin
          led      = 1'b1;
          bit_idx  = '0;
          cur_byte = buffer[byte_idx];
          phase    = PH_DATA;
        end
        PH_DATA: begin
          if (bit_idx >= BYTE_W) begin
            led   = 1'b0;
            phase = PH_STOP;
          end else begin
            led     = ~cur_byte[bit_idx[2:0]];
            bit_idx = bit_idx + 1'b1;
          end
        end
        default: begin
          if (nul_sent) begin
            phase  = PH_IDLE;
            active = 1'b0;
            fin    = 1'b1;
          end else begin
            if (cur_byte == '0) nul_sent = 1'b1;
            byte_idx = byte_idx + 1'b1;
            phase    = PH_START;
          end
        end
      endcase
      return fin;
    endfunction

    function void note_word(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                            logic [BYTE_W-1:0] data);
      int   eff;
      res_t r;
      eff    = (period == '0) ? 1 : int'(period);
      r.done = 1'b0;
      case (mode)
        MODE_WRITE: buffer[addr] = data;
        MODE_START: begin
          if (!active) begin
            active = 1'b1;
            phase  = PH_IDLE;
          end
        end
        MODE_TICK: begin
          if (int'(ticks) + 1 >= eff) begin
            ticks = '0;
            if (active) r.done = frame_step();
          end else begin
            ticks = ticks + 1'b1;
          end
        end
        default: ;
      endcase
      r.led_on = led;
      r.busy   = active;
      expected_q.push_back(r);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
        fails++;
      end
    endfunction

    function void check_word(logic led_on, logic busy, logic done);
      res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected, actual led_on %0b busy %0b done %0b",
                 $time, led_on, busy, done);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      compare_bit("led_on", want.led_on, led_on);
      compare_bit("busy", want.busy, busy);
      compare_bit("done", want.done, done);
    endfunction
  endclass

endpackage

FILE: test/tb_ir_uart_packet_transmitter.sv
// Bench for ir_uart_packet_transmitter: buffer loads, starts and timer ticks
// with random gaps on both channels, checked word by word against a tracker.
// Depends on irtx_pkg, irtx_tb_pkg and the RTL.
`timescale 1ns / 1ps
module tb_ir_uart_packet_transmitter;
  import irtx_pkg::*;
  import irtx_tb_pkg::*;

  // Unused mode code; the block must leave its state alone.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned WORDS_TARGET  = 1200;
  localparam int unsigned QUIET_LIMIT   = 5000;
  // Idle cycles waited before a cfg write, once all results are in.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [PERIOD_W-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic [MODE_W-1:0]   mode_i      = MODE_TICK;
  logic [ADDR_W-1:0]   address_i   = '0;
  logic [BYTE_W-1:0]   data_i      = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                led_on_o;
  logic                busy_res_o;
  logic                done_res_o;

  ir_uart_packet_transmitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .address_i   (address_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .led_on_o    (led_on_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  led_frame_tracker trk;
  int unsigned      src_idle   = 24;
  int unsigned      sink_idle  = 71;
  int unsigned      words_sent = 0;
  int unsigned      quiet      = 0;

  // Result side: check what is taken at this edge, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      trk.check_word(led_on_o, busy_res_o, done_res_o);
    out_ready_i <= ($urandom_range(99) >= sink_idle);
  end

  // Watchdog: any handshake resets the count of quiet cycles.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_ir_uart_packet_transmitter NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Drive one word and hold it until accepted. Valid only drops in a gap, so a
  // back-to-back word never sees a low and a high in the same step.
  task automatic push_word(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                           logic [BYTE_W-1:0] data);
    // idle profile: sender light / receiver heavy, then swapped, then none
    if (words_sent < 400) begin
      src_idle  = 24;
      sink_idle = 71;
    end else if (words_sent < 800) begin
      src_idle  = 71;
      sink_idle = 24;
    end else begin
      src_idle  = 0;
      sink_idle = 0;
    end
    if (src_idle != 0 && $urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    address_i  <= addr;
    data_i     <= data;
    do @(posedge clk_i); while (!in_ready_o);
    trk.note_word(mode, addr, data);
    words_sent++;
  endtask

  // Stray traffic: writes, unused mode, ticks, and starts if allowed.
  task automatic push_noise(bit with_start);
    int unsigned pick;
    pick = $urandom_range(with_start ? 3 : 2);
    case (pick)
      0:       push_word(MODE_WRITE, ADDR_W'($urandom_range(31)),
                         BYTE_W'($urandom_range(255)));
      1:       push_word(MODE_SPARE, ADDR_W'($urandom_range(31)),
                         BYTE_W'($urandom_range(255)));
      2:       push_word(MODE_TICK, ADDR_W'($urandom_range(31)),
                         BYTE_W'($urandom_range(255)));
      default: push_word(MODE_START, ADDR_W'($urandom_range(31)),
                         BYTE_W'($urandom_range(255)));
    endcase
  endtask

  // Sender holds off until every result is in.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (trk.expected_q.size() != 0);
  endtask

  // Only called with the transmitter idle.
  task automatic write_period(logic [PERIOD_W-1:0] p);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    trk.set_period(p);
    cfg_valid_i <= 1'b0;
  endtask

  // Load a packet, start it and tick until it ends. The no-NUL variant fills
  // the whole buffer so the index wraps; past a tick budget NULs get written
  // at random spots so every packet terminates.
  task automatic run_packet(int unsigned noise_pct, bit no_nul);
    int unsigned len;
    int unsigned tick_cap;
    int unsigned ticks_sent;
    tick_cap   = 400 * ((trk.period == '0) ? 1 : int'(trk.period));
    ticks_sent = 0;
    if (no_nul) begin
      for (int i = 0; i < BUF_DEPTH_DEF; i++)
        push_word(MODE_WRITE, ADDR_W'(i), BYTE_W'($urandom_range(1, 255)));
    end else begin
      len = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(5);
      for (int i = 0; i < len; i++)
        push_word(MODE_WRITE, ADDR_W'(i), BYTE_W'($urandom_range(1, 255)));
      push_word(MODE_WRITE, ADDR_W'(len), '0);
      // checksum slot; wraps to index 0 when the NUL sits at the top
      push_word(MODE_WRITE, ADDR_W'((len + 1) % BUF_DEPTH_DEF),
                BYTE_W'($urandom_range(255)));
    end
    push_word(MODE_START, ADDR_W'($urandom_range(31)), BYTE_W'($urandom_range(255)));
    while (trk.active) begin
      if (ticks_sent > tick_cap && ticks_sent % 32 == 0) begin
        push_word(MODE_WRITE, ADDR_W'($urandom_range(31)), '0);
        ticks_sent++;
      end else if ($urandom_range(99) < noise_pct) begin
        push_noise(1'b1);
      end else begin
        push_word(MODE_TICK, ADDR_W'($urandom_range(31)), BYTE_W'($urandom_range(255)));
        ticks_sent++;
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0]   fill;
    logic [PERIOD_W-1:0] period_set [5];
    int unsigned         pk;
    period_set = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd0};
    trk = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every entry so no transmission ever reads an unwritten byte.
    // Directed packet: FF 01 80, NUL, checksum A5.
    for (int i = 0; i < BUF_DEPTH_DEF; i++) begin
      case (i)
        0:       fill = 8'hFF;
        1:       fill = 8'h01;
        2:       fill = 8'h80;
        3:       fill = 8'h00;
        4:       fill = 8'hA5;
        default: fill = BYTE_W'($urandom_range(255));
      endcase
      push_word(MODE_WRITE, ADDR_W'(i), fill);
    end

    // Reset period: the timer free-runs while idle, unused mode is a no-op.
    push_word(MODE_SPARE, '1, '1);
    repeat (4) push_word(MODE_TICK, '1, '0);
    push_word(MODE_WRITE, '1, '0);

    // Zero period behaves as one step per tick; leftover tick count fires early.
    write_period('0);
    push_word(MODE_START, '0, '0);
    push_word(MODE_START, '1, '1);  // busy, ignored
    push_word(MODE_SPARE, '0, '0);
    repeat (3) push_word(MODE_TICK, '0, '0);
    push_word(MODE_WRITE, 5'd2, 8'h7E);  // lands before byte 2 is latched
    while (trk.active) push_word(MODE_TICK, '0, '0);

    // Random packets; period changes every third one, occasional hold-offs.
    pk = 0;
    while (words_sent < WORDS_TARGET) begin
      if (pk % 3 == 0)
        write_period(period_set[(pk / 3) % 5]);
      else if ($urandom_range(3) == 0)
        drain_results();
      repeat ($urandom_range(4)) push_noise(1'b0);
      run_packet($urandom_range(5, 25), pk == 1);
      pk++;
    end

    // Longest period: a start then traffic, no step comes due before the end.
    write_period('1);
    push_word(MODE_START, '1, '0);
    repeat (30) push_noise(1'b1);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (trk.fails == 0 && trk.expected_q.size() == 0)
      $display("tb_ir_uart_packet_transmitter OK");
    else
      $display("tb_ir_uart_packet_transmitter NOT OK");
    $finish;
  end

endmodule
